// ===== rtl/broadcast_share_round_robin_picker_macros.svh =====
// Assertion macros shared by the picker RTL.
`ifndef BROADCAST_SHARE_ROUND_ROBIN_PICKER_MACROS_SVH
`define BROADCAST_SHARE_ROUND_ROBIN_PICKER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define BSRRP_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("picker assertion failed");
// Next-cycle implication.
`define BSRRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("picker assertion failed");
`else
`define BSRRP_ASSERT(label, clk, rst, ante, cons)
`define BSRRP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/bsrrp_pkg.sv =====
package bsrrp_pkg;

  // Fixed field widths of the stream items.
  localparam int CPU_W      = 4;
  localparam int BATCH_W    = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // Configuration port.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam int RING_W = 5;
  localparam logic [0:0]        REG_ACTIVE_CPUS   = 1'b0;
  localparam logic [RING_W-1:0] ACTIVE_CPUS_RESET = 5'd16;
  localparam logic [RING_W-1:0] RING_MIN          = 5'd2;

  // Item kinds carried in tuser.
  localparam logic MODE_PUBLISH = 1'b0;
  localparam logic MODE_FETCH   = 1'b1;

  // Controller states.
  localparam int ST_W = 2;
  localparam logic [ST_W-1:0] ST_IDLE = 2'd0;
  localparam logic [ST_W-1:0] ST_SCAN = 2'd1;
  localparam logic [ST_W-1:0] ST_FIN  = 2'd2;

endpackage

// ===== rtl/bsrrp_slot_mem.sv =====
module bsrrp_slot_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [DW-1:0]    rd_q;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[rd_addr];
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

// ===== rtl/bsrrp_cfg.sv =====
module bsrrp_cfg #(
  parameter int MAX_CPUS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bsrrp_pkg::APB_AW-1:0]  paddr,
  input  logic [bsrrp_pkg::APB_DW-1:0]  pwdata,
  output logic [bsrrp_pkg::APB_DW-1:0]  prdata,
  output logic                          pready,
  output logic [bsrrp_pkg::RING_W-1:0]  ring_n
);

  logic [bsrrp_pkg::RING_W-1:0] active_cpus;
  logic                         reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[bsrrp_pkg::APB_AW-1] == bsrrp_pkg::REG_ACTIVE_CPUS);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_cpus <= bsrrp_pkg::ACTIVE_CPUS_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      active_cpus <= pwdata[bsrrp_pkg::RING_W-1:0];
    end
  end

  assign prdata = reg_hit ? bsrrp_pkg::APB_DW'(active_cpus) : '0;

  // The raw register is kept; the ring size is saturated into 2 .. MAX_CPUS.
  always_comb begin
    if (active_cpus < bsrrp_pkg::RING_MIN) begin
      ring_n = bsrrp_pkg::RING_MIN;
    end else if (32'(active_cpus) > MAX_CPUS) begin
      ring_n = bsrrp_pkg::RING_W'(MAX_CPUS);
    end else begin
      ring_n = active_cpus;
    end
  end

endmodule

// ===== rtl/broadcast_share_round_robin_picker.sv =====
// Round-robin picker for shared batches, one batch per producer slot.
// Input items arrive on s_tvalid/s_tready; tuser is the mode (publish or
// fetch), tdata holds cpu and batch_size. A publish item is taken while
// idle and yields no result. A fetch item yields one result on
// m_tvalid/m_tready: tuser is the found flag, tdata the source slot and size.
// A fetch scans one slot per cycle through a registered-read slot memory,
// visiting up to n-1 slots, n being the saturated ring size. A fetch by a
// cpu outside the ring skips the scan and returns a not-found result. The
// block returns to idle, ready for the next item, as the result is placed
// in the output register.
// The APB port holds active_cpus at address 0; write it only while idle.
// Reset empties every slot (sizes and served masks read as zero), sets the
// scan pointer to slot 1 and active_cpus to 16. There is no clearing pass.
// When the receiver stalls, the result waits in the output register and the
// block still takes items while idle; the next fetch result then waits in
// the controller until the output register frees.
module broadcast_share_round_robin_picker #(
  parameter int MAX_CPUS  = 16,
  parameter int SIZE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bsrrp_pkg::APB_AW-1:0]      paddr,
  input  logic [bsrrp_pkg::APB_DW-1:0]      pwdata,
  output logic [bsrrp_pkg::APB_DW-1:0]      prdata,
  output logic                              pready,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bsrrp_pkg::IN_DATA_W-1:0]   s_tdata,   // cpu[3:0], batch_size[19:4]
  input  logic                              s_tuser,   // mode
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bsrrp_pkg::OUT_DATA_W-1:0]  m_tdata,   // source_slot[3:0], delivered_size[19:4]
  output logic                              m_tuser    // found
);

`include "broadcast_share_round_robin_picker_macros.svh"

  localparam int SLOT_W  = $clog2(MAX_CPUS);
  localparam int ENTRY_W = SIZE_BITS + MAX_CPUS;

  function automatic logic [7:0] ring_next(input logic [7:0] p, input logic [7:0] n);
    logic [7:0] q;
    q = p + 8'd1;
    return (q >= n) ? 8'd1 : q;
  endfunction

  logic [bsrrp_pkg::RING_W-1:0]  ring_n;
  logic [7:0]                    n8;
  logic [ENTRY_W-1:0]            rd_data;
  logic [ENTRY_W-1:0]            wr_data;
  logic [SLOT_W-1:0]             rd_addr;
  logic [SLOT_W-1:0]             wr_addr;
  logic                          wr_en;

  logic [bsrrp_pkg::ST_W-1:0]    state;
  logic [SLOT_W-1:0]             scan_start;
  logic [SLOT_W-1:0]             start_slot;
  logic [SLOT_W-1:0]             rd_slot;
  logic [SLOT_W-1:0]             cpu_q;
  logic [bsrrp_pkg::RING_W-1:0]  remaining;
  logic                          res_found;
  logic [SLOT_W-1:0]             res_slot;
  logic [SIZE_BITS-1:0]          res_size;

  logic                          accept;
  logic [bsrrp_pkg::CPU_W-1:0]   in_cpu;
  logic [bsrrp_pkg::BATCH_W-1:0] in_batch;
  logic [SIZE_BITS-1:0]          size_in;
  logic                          cpu_in_ring;
  logic [SIZE_BITS-1:0]          ent_size;
  logic [MAX_CPUS-1:0]           ent_mask;
  logic [MAX_CPUS-1:0]           mask_set;
  logic                          hit;
  logic                          out_load;
  logic [bsrrp_pkg::BATCH_W-1:0] size_out;
  logic [bsrrp_pkg::CPU_W-1:0]   slot_out;

  bsrrp_cfg #(
    .MAX_CPUS(MAX_CPUS)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ring_n  (ring_n)
  );

  bsrrp_slot_mem #(
    .DEPTH(MAX_CPUS),
    .AW   (SLOT_W),
    .DW   (ENTRY_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign n8       = 8'(ring_n);
  assign in_cpu   = s_tdata[bsrrp_pkg::CPU_W-1:0];
  assign in_batch = s_tdata[bsrrp_pkg::CPU_W +: bsrrp_pkg::BATCH_W];
  assign s_tready = (state == bsrrp_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign cpu_in_ring = (8'(in_cpu) < n8);

  // Batch sizes are kept in their low SIZE_BITS bits.
  for (genvar i = 0; i < SIZE_BITS; i++) begin : g_size_in
    if (i < bsrrp_pkg::BATCH_W) begin : g_bit
      assign size_in[i] = in_batch[i];
    end else begin : g_zero
      assign size_in[i] = 1'b0;
    end
  end

  for (genvar i = 0; i < bsrrp_pkg::BATCH_W; i++) begin : g_size_out
    if (i < SIZE_BITS) begin : g_bit
      assign size_out[i] = res_size[i];
    end else begin : g_zero
      assign size_out[i] = 1'b0;
    end
  end

  assign slot_out = bsrrp_pkg::CPU_W'(res_slot);

  // A pointer left beyond a lowered ring restarts at slot 1.
  assign start_slot = ((8'(scan_start) >= n8) || (scan_start == '0))
                      ? SLOT_W'(1) : scan_start;

  assign ent_size = rd_data[ENTRY_W-1:MAX_CPUS];
  assign ent_mask = rd_data[MAX_CPUS-1:0];

  always_comb begin
    mask_set        = ent_mask;
    mask_set[cpu_q] = 1'b1;
  end

  assign hit = (state == bsrrp_pkg::ST_SCAN) && (rd_slot != cpu_q) &&
               (ent_size != '0) && !ent_mask[cpu_q];

  // While idle the first slot of the scan is fetched ahead of acceptance.
  assign rd_addr = (state == bsrrp_pkg::ST_SCAN)
                   ? SLOT_W'(ring_next(8'(rd_slot), n8)) : start_slot;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_slot;
    wr_data = {ent_size, mask_set};
    if (hit) begin
      wr_en = 1'b1;
    end else if (accept && (s_tuser == bsrrp_pkg::MODE_PUBLISH) && cpu_in_ring) begin
      wr_en   = 1'b1;
      wr_addr = SLOT_W'(in_cpu);
      wr_data = {size_in, {MAX_CPUS{1'b0}}};
    end
  end

  assign out_load = (state == bsrrp_pkg::ST_FIN) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    rd_slot <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bsrrp_pkg::ST_IDLE;
      scan_start <= SLOT_W'(1);
      remaining  <= '0;
    end else begin
      unique case (state)
        bsrrp_pkg::ST_IDLE: begin
          if (accept && (s_tuser == bsrrp_pkg::MODE_FETCH)) begin
            scan_start <= SLOT_W'(ring_next(8'(start_slot), n8));
            cpu_q      <= SLOT_W'(in_cpu);
            remaining  <= ring_n - bsrrp_pkg::RING_W'(1);
            res_found  <= 1'b0;
            res_slot   <= '0;
            res_size   <= '0;
            state      <= cpu_in_ring ? bsrrp_pkg::ST_SCAN : bsrrp_pkg::ST_FIN;
          end
        end
        bsrrp_pkg::ST_SCAN: begin
          if (hit) begin
            res_found <= 1'b1;
            res_slot  <= rd_slot;
            res_size  <= ent_size;
            state     <= bsrrp_pkg::ST_FIN;
          end else if (remaining == bsrrp_pkg::RING_W'(1)) begin
            state <= bsrrp_pkg::ST_FIN;
          end else begin
            remaining <= remaining - bsrrp_pkg::RING_W'(1);
          end
        end
        bsrrp_pkg::ST_FIN: begin
          if (out_load) begin
            state <= bsrrp_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= bsrrp_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Output register: a finished result waits here while the block goes on.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= res_found;
      m_tdata <= bsrrp_pkg::OUT_DATA_W'({size_out, slot_out});
    end
  end

  `BSRRP_ASSERT(a_hit_not_slot0, clk, rst, hit, rd_slot != '0)
  `BSRRP_ASSERT(a_miss_zero, clk, rst, m_tvalid && !m_tuser, m_tdata == '0)
  `BSRRP_ASSERT(a_start_nonzero, clk, rst, 1'b1, scan_start != '0)
  `BSRRP_ASSERT(a_scan_bounded, clk, rst, state == bsrrp_pkg::ST_SCAN, remaining != '0)
  `BSRRP_ASSERT_NEXT(a_hit_finishes, clk, rst, hit, state == bsrrp_pkg::ST_FIN && res_found)

endmodule

// ===== tb/tb_broadcast_share_round_robin_picker.sv =====
module tb_broadcast_share_round_robin_picker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_SLOTS     = 16;
  localparam int N_PHASES    = 9;
  localparam int RAND_ITEMS  = 220;
  localparam int SETTLE      = 24;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [bsrrp_pkg::APB_AW-1:0] ADDR_ACTIVE_CPUS =
    {bsrrp_pkg::REG_ACTIVE_CPUS, 2'b00};

  typedef struct packed {
    logic                          found;
    logic [bsrrp_pkg::CPU_W-1:0]   slot;
    logic [bsrrp_pkg::BATCH_W-1:0] size;
  } pick_t;

  typedef struct packed {
    logic                          mode;
    logic [bsrrp_pkg::CPU_W-1:0]   cpu;
    logic [bsrrp_pkg::BATCH_W-1:0] size;
    bit                            typed_miss;
  } row_t;

  logic                             clk;
  logic                             rst;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [bsrrp_pkg::APB_AW-1:0]     paddr;
  logic [bsrrp_pkg::APB_DW-1:0]     pwdata;
  logic [bsrrp_pkg::APB_DW-1:0]     prdata;
  logic                             pready;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [bsrrp_pkg::IN_DATA_W-1:0]  s_tdata;   // cpu[3:0], batch_size[19:4]
  logic                             s_tuser;   // mode
  logic                             m_tvalid;
  logic                             m_tready;
  logic [bsrrp_pkg::OUT_DATA_W-1:0] m_tdata;   // source_slot[3:0], delivered_size[19:4]
  logic                             m_tuser;   // found

  // Shadow of the picker state.
  logic [bsrrp_pkg::BATCH_W-1:0] shadow_size [N_SLOTS];
  logic [N_SLOTS-1:0]            shadow_served [N_SLOTS];
  int                            shadow_ptr;
  logic [bsrrp_pkg::RING_W-1:0]  shadow_active;

  pick_t picks_due [$];
  row_t  dir_rows [$];
  int    fail_count;
  int    cycle_count;
  bit    calm;
  bit    hold_req;
  bit    hold_done;

  broadcast_share_round_robin_picker DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int ring_size();
    if (shadow_active < bsrrp_pkg::RING_MIN) return bsrrp_pkg::RING_MIN;
    if (shadow_active > N_SLOTS) return N_SLOTS;
    return shadow_active;
  endfunction

  function automatic logic [bsrrp_pkg::RING_W-1:0] ring_setting(input int ph);
    unique case (ph)
      0: return 5'd16;
      1: return 5'd2;
      2: return 5'd5;
      3: return 5'd0;
      4: return 5'd31;
      5: return 5'd9;
      6: return 5'd1;
      7: return 5'd17;
      default: return 5'd12;
    endcase
  endfunction

  // Applies one item to the shadow state; returns 1 when the item yields a result.
  function automatic bit pick_apply(input logic mode,
                                    input logic [bsrrp_pkg::CPU_W-1:0] cpu,
                                    input logic [bsrrp_pkg::BATCH_W-1:0] size,
                                    output pick_t res);
    int n;
    int p;
    int start;
    n = ring_size();
    res = '0;
    if (mode == bsrrp_pkg::MODE_PUBLISH) begin
      if (cpu < n) begin
        shadow_size[cpu] = size;
        shadow_served[cpu] = '0;
      end
      return 1'b0;
    end
    // A pointer left beyond a shrunken ring restarts at slot 1.
    start = (shadow_ptr >= n || shadow_ptr == 0) ? 1 : shadow_ptr;
    if (cpu < n) begin
      p = start;
      for (int k = 0; k < n - 1; k++) begin
        if (!res.found && p != cpu && shadow_size[p] != '0 && !shadow_served[p][cpu]) begin
          shadow_served[p][cpu] = 1'b1;
          res.found = 1'b1;
          res.slot  = bsrrp_pkg::CPU_W'(p);
          res.size  = shadow_size[p];
        end
        p = (p + 1 >= n) ? 1 : p + 1;
      end
    end
    shadow_ptr = (start + 1 >= n) ? 1 : start + 1;
    return 1'b1;
  endfunction

  task automatic send_item(input logic mode, input logic [bsrrp_pkg::CPU_W-1:0] cpu,
                           input logic [bsrrp_pkg::BATCH_W-1:0] size,
                           input bit typed_miss);
    pick_t res;
    bit    has_res;
    while (!calm && $urandom_range(99) < 21) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {4'b0, size, cpu};
    do @(posedge clk); while (!s_tready);
    has_res = pick_apply(mode, cpu, size, res);
    if (has_res) picks_due.push_back(typed_miss ? pick_t'('0) : res);
  endtask

  task automatic ring_write(input logic [bsrrp_pkg::RING_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ACTIVE_CPUS;
    pwdata  <= {{(bsrrp_pkg::APB_DW-bsrrp_pkg::RING_W){1'b0}}, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_active = val;
  endtask

  // Waits for every pending result, then for a fetch that may still be scanning.
  task automatic drain();
    while (picks_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    pick_t got;
    pick_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.found = m_tuser;
      got.slot  = m_tdata[3:0];
      got.size  = m_tdata[19:4];
      if (picks_due.size() == 0) begin
        $display("%0t: unexpected result found=%0d slot=%0d size=%0d",
                 $time, got.found, got.slot, got.size);
        fail_count++;
      end else begin
        want = picks_due.pop_front();
        if (got.found !== want.found) begin
          $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
          fail_count++;
        end
        if (got.slot !== want.slot) begin
          $display("%0t: source_slot expected %0d actual %0d", $time, want.slot, got.slot);
          fail_count++;
        end
        if (got.size !== want.size) begin
          $display("%0t: delivered_size expected %0d actual %0d",
                   $time, want.size, got.size);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, none in the calm phase, and one long hold-off on request.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (calm) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 21);
      end
    end
  end

  initial begin
    int                            n;
    int                            r;
    logic                          mode;
    logic [bsrrp_pkg::CPU_W-1:0]   cpu;
    logic [bsrrp_pkg::BATCH_W-1:0] size;

    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= bsrrp_pkg::MODE_PUBLISH;
    fail_count  = 0;
    cycle_count = 0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    hold_done   = 1'b0;
    for (int i = 0; i < N_SLOTS; i++) begin
      shadow_size[i]   = '0;
      shadow_served[i] = '0;
    end
    shadow_ptr    = 1;
    shadow_active = bsrrp_pkg::ACTIVE_CPUS_RESET;

    // Directed rows; the ones flagged at the end expect nothing found.
    dir_rows.push_back({bsrrp_pkg::MODE_FETCH,   4'd3,  16'h0000, 1'b1});
    dir_rows.push_back({bsrrp_pkg::MODE_FETCH,   4'd15, 16'h0000, 1'b1});
    dir_rows.push_back({bsrrp_pkg::MODE_PUBLISH, 4'd0,  16'hFFFF, 1'b0});
    dir_rows.push_back({bsrrp_pkg::MODE_PUBLISH, 4'd15, 16'hFFFF, 1'b0});
    dir_rows.push_back({bsrrp_pkg::MODE_PUBLISH, 4'd5,  16'h0000, 1'b0});
    dir_rows.push_back({bsrrp_pkg::MODE_PUBLISH, 4'd7,  16'h0001, 1'b0});
    dir_rows.push_back({bsrrp_pkg::MODE_FETCH,   4'd0,  16'h0000, 1'b0});
    dir_rows.push_back({bsrrp_pkg::MODE_FETCH,   4'd15, 16'h0000, 1'b0});
    dir_rows.push_back({bsrrp_pkg::MODE_FETCH,   4'd15, 16'h0000, 1'b0});
    dir_rows.push_back({bsrrp_pkg::MODE_FETCH,   4'd7,  16'h0000, 1'b0});
    dir_rows.push_back({bsrrp_pkg::MODE_FETCH,   4'd0,  16'h0000, 1'b0});
    dir_rows.push_back({bsrrp_pkg::MODE_PUBLISH, 4'd7,  16'hAAAA, 1'b0});
    dir_rows.push_back({bsrrp_pkg::MODE_FETCH,   4'd15, 16'h0000, 1'b0});
    dir_rows.push_back({bsrrp_pkg::MODE_FETCH,   4'd15, 16'h0000, 1'b0});
    dir_rows.push_back({bsrrp_pkg::MODE_FETCH,   4'd1,  16'h0000, 1'b0});
    dir_rows.push_back({bsrrp_pkg::MODE_PUBLISH, 4'd1,  16'h5555, 1'b0});
    dir_rows.push_back({bsrrp_pkg::MODE_FETCH,   4'd1,  16'h0000, 1'b0});
    dir_rows.push_back({bsrrp_pkg::MODE_FETCH,   4'd2,  16'h0000, 1'b0});
    dir_rows.push_back({bsrrp_pkg::MODE_FETCH,   4'd3,  16'h0000, 1'b0});
    dir_rows.push_back({bsrrp_pkg::MODE_FETCH,   4'd0,  16'hFFFF, 1'b0});
    dir_rows.push_back({bsrrp_pkg::MODE_FETCH,   4'd15, 16'h1234, 1'b0});

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      ring_write(ring_setting(ph));
      n = ring_size();
      calm = (ph == 3);
      if (ph == 0) begin
        foreach (dir_rows[i])
          send_item(dir_rows[i].mode, dir_rows[i].cpu, dir_rows[i].size,
                    dir_rows[i].typed_miss);
      end
      for (int i = 0; i < RAND_ITEMS; i++) begin
        if (ph == 5 && i == 40) hold_req = 1'b1;
        mode = ($urandom_range(99) < 35) ? bsrrp_pkg::MODE_PUBLISH : bsrrp_pkg::MODE_FETCH;
        // Mostly cpus inside the ring; the rest may fall outside it.
        cpu = ($urandom_range(99) < 85) ? bsrrp_pkg::CPU_W'($urandom_range(n - 1))
                                        : bsrrp_pkg::CPU_W'($urandom_range(N_SLOTS - 1));
        r = $urandom_range(99);
        size = (r < 10) ? 16'h0000 :
               (r < 20) ? 16'hFFFF : bsrrp_pkg::BATCH_W'($urandom_range(16'hFFFF));
        send_item(mode, cpu, size, 1'b0);
      end
      s_tvalid <= 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
